/* hdl/mpk_pkg.sv */
// ----------------------------------------------------------------------------
// mpk_pkg
// Shared types and constants of the Morse paddle keyer: payload structs,
// configuration register map, reset values and state encodings.
// ----------------------------------------------------------------------------
package mpk_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 14;

    // Width of a phase length before it is fitted into the counter.
    localparam int LEN_W = 14;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int DIV_STEPS = 12;
    localparam int DIV_CNT_W = 4;

    // Register indexes.
    localparam logic [1:0] REG_UNIT_CONSTANT = 2'd0;
    localparam logic [1:0] REG_REPEAT_MS     = 2'd1;
    localparam logic [1:0] REG_WPM_MIN       = 2'd2;
    localparam logic [1:0] REG_WPM_MAX       = 2'd3;

    localparam logic [11:0] UNIT_CONSTANT_RESET = 12'd1200;
    localparam logic [9:0]  REPEAT_MS_RESET     = 10'd100;
    localparam logic [7:0]  WPM_MIN_RESET       = 8'd1;
    localparam logic [7:0]  WPM_MAX_RESET       = 8'd60;

    localparam logic [7:0]  SPEED_RESET = 8'd10;
    localparam logic [11:0] UNIT_RESET  = 12'd120;

    typedef struct packed {
        logic dot_pressed;
        logic dash_pressed;
        logic faster_pressed;
        logic slower_pressed;
    } tick_t;

    typedef struct packed {
        logic        key_down;
        logic [7:0]  words_per_minute;
        logic [11:0] unit_ms;
    } result_t;

    typedef struct packed {
        logic [11:0] unit_constant;
        logic [9:0]  repeat_ms;
        logic [7:0]  wpm_min;
        logic [7:0]  wpm_max;
    } cfg_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_DOT_ON    = 3'd1,
        PH_DOT_OFF   = 3'd2,
        PH_DASH_ON   = 3'd3,
        PH_DASH_OFF  = 3'd4,
        PH_FAST_WAIT = 3'd5,
        PH_SLOW_WAIT = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DIV,
        C_START,
        C_RUN,
        C_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic do_start;
        logic do_run;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_idle;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/morse_paddle_keyer_top.sv */
// ----------------------------------------------------------------------------
// morse_paddle_keyer_top
// Iambic-style paddle keyer taking one button word per millisecond tick and
// returning the key line, speed and unit length for that tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Word
//  tick      in         tick_valid/stall     tick_t   (four buttons)
//  result    out        result_valid/stall   result_t (key, wpm, unit)
//  config    in         APB psel/penable     four registers at 4*index
//
// A tick that finds the keyer idle passes through accept, the steps of the
// restoring unit divider, a start step, a phase step and the output load.
// Other ticks skip the divider and start step. The divider sets the worst case.
// A stalled result waits in the output register; the next tick is taken
// meanwhile and is held in its final step until that register frees up.
// Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module morse_paddle_keyer_top
    import mpk_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  tick_t                 tick,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready = 1'b1;

    mpk_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mpk_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .status     (status),
        .cmd        (cmd)
    );

    mpk_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

/* hdl/mpk_cfg.sv */
// ----------------------------------------------------------------------------
// mpk_cfg
// APB register block holding the four keyer configuration registers.
// ----------------------------------------------------------------------------
module mpk_cfg
    import mpk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [1:0] index;
    logic       wr_en;

    assign index = paddr[3:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_constant <= UNIT_CONSTANT_RESET;
            cfg_reg.repeat_ms     <= REPEAT_MS_RESET;
            cfg_reg.wpm_min       <= WPM_MIN_RESET;
            cfg_reg.wpm_max       <= WPM_MAX_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_UNIT_CONSTANT: cfg_reg.unit_constant <= pwdata[11:0];
                REG_REPEAT_MS:     cfg_reg.repeat_ms     <= pwdata[9:0];
                REG_WPM_MIN:       cfg_reg.wpm_min       <= pwdata[7:0];
                REG_WPM_MAX:       cfg_reg.wpm_max       <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_UNIT_CONSTANT: prdata = APB_DATA_W'(cfg_reg.unit_constant);
            REG_REPEAT_MS:     prdata = APB_DATA_W'(cfg_reg.repeat_ms);
            REG_WPM_MIN:       prdata = APB_DATA_W'(cfg_reg.wpm_min);
            REG_WPM_MAX:       prdata = APB_DATA_W'(cfg_reg.wpm_max);
            default:           prdata = '0;
        endcase
    end

endmodule

/* hdl/mpk_ctrl.sv */
// ----------------------------------------------------------------------------
// mpk_ctrl
// Sequencer for one tick: accept, optional unit division, idle start step,
// phase step, and hand-off to the output register.
// ----------------------------------------------------------------------------
module mpk_ctrl
    import mpk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (tick_valid)
                    state_next = status.phase_idle ? C_DIV : C_RUN;
            end
            C_DIV:
            begin
                if (status.div_last)
                    state_next = C_START;
            end
            C_START: state_next = C_RUN;
            C_RUN:   state_next = C_DONE;
            C_DONE:
            begin
                if (status.out_free)
                    state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        tick_stall = 1'b1;
        case (state_reg)
            C_IDLE:
            begin
                tick_stall = 1'b0;
                cmd.accept = tick_valid;
            end
            C_DIV:   cmd.div_step = 1'b1;
            C_START: cmd.do_start = 1'b1;
            C_RUN:   cmd.do_run   = 1'b1;
            C_DONE:  cmd.load_out = status.out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/mpk_datapath.sv */
// ----------------------------------------------------------------------------
// mpk_datapath
// Keyer state, restoring unit divider, phase timing and the output register.
// ----------------------------------------------------------------------------
module mpk_datapath
    import mpk_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  tick_t      tick,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  dp_cmd_t    cmd,
    output dp_status_t status
);

    localparam int XW = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
    localparam logic [XW-1:0] CMAX_X = XW'({COUNT_WIDTH{1'b1}});

    tick_t                  btn_reg;
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] ms_left_reg, ms_left_next;
    logic [7:0]             speed_reg, speed_next;
    logic [11:0]            unit_len_reg, unit_len_next;
    logic                   key_reg, key_next;
    logic [11:0]            quot_reg;
    logic [7:0]             rem_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    result_t                out_reg;
    logic                   out_valid_reg;

    logic [7:0]             divisor;
    logic [8:0]             trial;
    logic                   trial_ge;
    logic [11:0]            eff_unit;
    logic [LEN_W-1:0]       unit_len1;
    logic [LEN_W-1:0]       unit_len3;
    logic [LEN_W-1:0]       repeat_len;
    logic [COUNT_WIDTH-1:0] ms_dec;

    // Fits a phase length into the counter: zero becomes one, overflow saturates.
    function automatic logic [COUNT_WIDTH-1:0] fit_len(input logic [LEN_W-1:0] len);
        logic [XW-1:0] lx;
        lx = XW'(len);
        if (lx == '0)
            lx = XW'(1);
        if (lx > CMAX_X)
            lx = CMAX_X;
        return COUNT_WIDTH'(lx);
    endfunction

    function automatic logic [7:0] speed_up(input logic [7:0] s, input logic [7:0] lim);
        logic [7:0] r;
        r = (s >= lim) ? lim : s + 8'd1;
        if (r == 8'd0)
            r = 8'd1;
        return r;
    endfunction

    function automatic logic [7:0] speed_down(input logic [7:0] s, input logic [7:0] lim);
        logic [7:0] r;
        r = (s <= lim) ? lim : s - 8'd1;
        if (r == 8'd0)
            r = 8'd1;
        return r;
    endfunction

    // One restoring division step per cycle; the quotient shifts in from the right.
    assign divisor  = (speed_reg == 8'd0) ? 8'd1 : speed_reg;
    assign trial    = {rem_reg, quot_reg[11]};
    assign trial_ge = trial >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            btn_reg  <= tick;
            quot_reg <= cfg.unit_constant;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[10:0], trial_ge};
            rem_reg  <= trial_ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.accept)
            div_cnt_reg <= '0;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
    end

    // In the start step the new unit comes straight from the divider.
    assign eff_unit   = cmd.do_start ? ((quot_reg == 12'd0) ? 12'd1 : quot_reg)
                                     : ((unit_len_reg == 12'd0) ? 12'd1 : unit_len_reg);
    assign unit_len1  = LEN_W'(eff_unit);
    assign unit_len3  = LEN_W'(eff_unit) + LEN_W'({eff_unit, 1'b0});
    assign repeat_len = LEN_W'(cfg.repeat_ms);
    assign ms_dec     = (ms_left_reg != '0) ? ms_left_reg - COUNT_WIDTH'(1) : ms_left_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        ms_left_next  = ms_left_reg;
        speed_next    = speed_reg;
        unit_len_next = unit_len_reg;
        key_next      = key_reg;

        if (cmd.do_start)
        begin
            unit_len_next = quot_reg;
            if (btn_reg.dot_pressed)
            begin
                phase_next   = PH_DOT_ON;
                ms_left_next = fit_len(unit_len1);
            end
            else if (btn_reg.dash_pressed)
            begin
                phase_next   = PH_DASH_ON;
                ms_left_next = fit_len(unit_len3);
            end
            else if (btn_reg.faster_pressed)
            begin
                speed_next   = speed_up(speed_reg, cfg.wpm_max);
                phase_next   = PH_FAST_WAIT;
                ms_left_next = fit_len(repeat_len);
            end
            else if (btn_reg.slower_pressed)
            begin
                speed_next   = speed_down(speed_reg, cfg.wpm_min);
                phase_next   = PH_SLOW_WAIT;
                ms_left_next = fit_len(repeat_len);
            end
        end

        if (cmd.do_run)
        begin
            key_next     = (phase_reg == PH_DOT_ON) || (phase_reg == PH_DASH_ON);
            ms_left_next = ms_dec;
            if (phase_reg != PH_IDLE && ms_dec == '0)
            begin
                case (phase_reg)
                    PH_DOT_ON:
                    begin
                        phase_next   = PH_DOT_OFF;
                        ms_left_next = fit_len(unit_len1);
                    end
                    PH_DOT_OFF:
                    begin
                        if (btn_reg.dot_pressed)
                        begin
                            phase_next   = PH_DOT_ON;
                            ms_left_next = fit_len(unit_len1);
                        end
                        else
                            phase_next = PH_IDLE;
                    end
                    PH_DASH_ON:
                    begin
                        phase_next   = PH_DASH_OFF;
                        ms_left_next = fit_len(unit_len1);
                    end
                    PH_DASH_OFF:
                    begin
                        if (btn_reg.dash_pressed)
                        begin
                            phase_next   = PH_DASH_ON;
                            ms_left_next = fit_len(unit_len3);
                        end
                        else
                            phase_next = PH_IDLE;
                    end
                    PH_FAST_WAIT:
                    begin
                        if (btn_reg.faster_pressed)
                        begin
                            speed_next   = speed_up(speed_reg, cfg.wpm_max);
                            ms_left_next = fit_len(repeat_len);
                        end
                        else
                            phase_next = PH_IDLE;
                    end
                    PH_SLOW_WAIT:
                    begin
                        if (btn_reg.slower_pressed)
                        begin
                            speed_next   = speed_down(speed_reg, cfg.wpm_min);
                            ms_left_next = fit_len(repeat_len);
                        end
                        else
                            phase_next = PH_IDLE;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            ms_left_reg  <= '0;
            speed_reg    <= SPEED_RESET;
            unit_len_reg <= UNIT_RESET;
            key_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ms_left_reg  <= ms_left_next;
            speed_reg    <= speed_next;
            unit_len_reg <= unit_len_next;
            key_reg      <= key_next;
        end
    end

    // Output register: a finished word waits here while the next tick is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.key_down         <= key_reg;
            out_reg.words_per_minute <= speed_reg;
            out_reg.unit_ms          <= unit_len_reg;
        end
    end

    assign result_valid      = out_valid_reg;
    assign result            = out_reg;
    assign status.phase_idle = (phase_reg == PH_IDLE);
    assign status.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_free   = !out_valid_reg || !result_stall;

endmodule
